@@ hdl/urlqd_pkg.sv @@
`timescale 1ns / 1ps

package urlqd_pkg;

  // Parsing phase of the URL.
  typedef enum logic [1:0] {
    PH_SEEK  = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  // Progress through a percent escape.
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_e;

  // Kind of one result transaction.
  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned SlotW      = $clog2(MaxResults);
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  // One result as it sits in the queue.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } entry_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [CountW-1:0]             cnt;
    entry_t [MaxResults-1:0]       ent;
  } bundle_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } qhead_t;

  // Returns {is_hex, nibble} for an ASCII character.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_ZERO && c <= 8'h39) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (c >= CH_UPPER_A && c <= 8'h46) begin
      r = {1'b1, 4'(c - CH_UPPER_A) + HEX_TEN};
    end else if (c >= CH_LOWER_A && c <= 8'h66) begin
      r = {1'b1, 4'(c - CH_LOWER_A) + HEX_TEN};
    end
    return r;
  endfunction

  // Appends one result to a bundle; extra results beyond the limit are dropped.
  function automatic bundle_t push(input bundle_t b, input kind_e k, input logic [7:0] d);
    bundle_t r;
    r = b;
    if (b.cnt < CountW'(MaxResults)) begin
      r.ent[b.cnt[SlotW-1:0]].kind = k;
      r.ent[b.cnt[SlotW-1:0]].data = d;
      r.cnt = b.cnt + CountW'(1);
    end
    return r;
  endfunction

endpackage

@@ hdl/urlqd_in_if.sv @@
`timescale 1ns / 1ps

interface urlqd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_url;

  modport source (output valid, output in_byte, output end_of_url, input ready);
  modport sink (input valid, input in_byte, input end_of_url, output ready);
endinterface

@@ hdl/urlqd_out_if.sv @@
`timescale 1ns / 1ps

interface urlqd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] out_byte;
  logic       last_result;

  modport source (output valid, output item_kind, output out_byte, output last_result,
                  input ready);
  modport sink (input valid, input item_kind, input out_byte, input last_result,
                output ready);
endinterface

@@ hdl/urlqd_front.sv @@
`timescale 1ns / 1ps

module urlqd_front
  import urlqd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  urlqd_in_if.sink in_i,
  input  logic     full_i,
  output logic     push_o,
  output bundle_t  bundle_o
);

  phase_e     phase_q, phase_d;
  esc_e       esc_q, esc_d;
  logic [7:0] held_q, held_d;
  logic       pair_open_q, pair_open_d;

  logic       accept;
  bundle_t    b;
  logic [7:0] c;
  logic [4:0] hex_c, hex_h;
  logic       flush, plain;
  kind_e      fkind;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  // Classify the byte and collect every result it causes.
  always_comb begin
    b           = '0;
    c           = in_i.in_byte;
    phase_d     = phase_q;
    esc_d       = esc_q;
    held_d      = held_q;
    pair_open_d = pair_open_q;
    flush       = 1'b0;
    plain       = 1'b0;
    hex_c       = hex_decode(c);
    hex_h       = hex_decode(held_q);

    if (phase_q != PH_KEY && phase_q != PH_VALUE) begin
      if (c == CH_QMARK) begin
        phase_d = PH_KEY;
      end else begin
        phase_d = PH_SEEK;
      end
    end else if (esc_q == ESC_PCT) begin
      if (hex_c[4]) begin
        held_d = c;
        esc_d  = ESC_DIGIT;
      end else begin
        flush = 1'b1;
        plain = 1'b1;
      end
    end else if (esc_q == ESC_DIGIT) begin
      if (hex_c[4] && hex_h[4]) begin
        fkind = (phase_q == PH_VALUE) ? KIND_VALUE : KIND_KEY;
        b     = push(b, fkind, {hex_h[3:0], hex_c[3:0]});
        esc_d = ESC_NONE;
      end else begin
        flush = 1'b1;
        plain = 1'b1;
      end
    end else begin
      esc_d = ESC_NONE;
      plain = 1'b1;
    end

    fkind = (phase_d == PH_VALUE) ? KIND_VALUE : KIND_KEY;

    // An invalid escape comes out literally before the byte itself.
    if (flush) begin
      if (esc_d != ESC_NONE) b = push(b, fkind, CH_PCT);
      if (esc_d == ESC_DIGIT) b = push(b, fkind, held_d);
      esc_d = ESC_NONE;
    end

    // Ordinary byte inside the query.
    if (plain) begin
      if (c == CH_AMP) begin
        b           = push(b, KIND_END, 8'h00);
        pair_open_d = 1'b0;
        phase_d     = PH_KEY;
      end else begin
        pair_open_d = 1'b1;
        if (c == CH_EQ && phase_d == PH_KEY) begin
          phase_d = PH_VALUE;
        end else if (c == CH_PCT) begin
          esc_d = ESC_PCT;
        end else if (c == CH_PLUS) begin
          b = push(b, fkind, CH_SPACE);
        end else begin
          b = push(b, fkind, c);
        end
      end
    end

    // Close out the URL: cut-off escape, open pair, then back to reset state.
    if (in_i.end_of_url) begin
      fkind = (phase_d == PH_VALUE) ? KIND_VALUE : KIND_KEY;
      if (phase_d == PH_KEY || phase_d == PH_VALUE) begin
        if (esc_d != ESC_NONE) b = push(b, fkind, CH_PCT);
        if (esc_d == ESC_DIGIT) b = push(b, fkind, held_d);
        if (pair_open_d) b = push(b, KIND_END, 8'h00);
      end
      phase_d     = PH_SEEK;
      esc_d       = ESC_NONE;
      held_d      = '0;
      pair_open_d = 1'b0;
    end
  end

  assign bundle_o = b;
  assign push_o   = accept && (b.cnt != '0);

  // Parser state advances on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEEK;
      esc_q       <= ESC_NONE;
      held_q      <= '0;
      pair_open_q <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      esc_q       <= esc_d;
      held_q      <= held_d;
      pair_open_q <= pair_open_d;
    end
  end

endmodule

@@ hdl/urlqd_queue.sv @@
`timescale 1ns / 1ps

module urlqd_queue
  import urlqd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  output logic    full_o,
  input  logic    pop_i,
  output qhead_t  head_o
);

  bundle_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (count_q != 2'd0);

  // Storage for two bundles.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= bundle_i;
  end

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 2'd1;
    if (!do_push && do_pop) count_d = count_q - 2'd1;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      count_q <= count_d;
    end
  end

  assign head_o.valid  = (count_q != 2'd0);
  assign head_o.bundle = mem_q[rd_q];

endmodule

@@ hdl/urlqd_back.sv @@
`timescale 1ns / 1ps

module urlqd_back
  import urlqd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  qhead_t       head_i,
  output logic         pop_o,
  urlqd_out_if.source  out_o
);

  logic [SlotW-1:0] idx_q;
  logic             is_last;
  logic             xfer;
  entry_t           cur;

  // Walk through the results of the bundle at the head of the queue.
  assign cur     = head_i.bundle.ent[idx_q];
  assign is_last = ({1'b0, idx_q} == (head_i.bundle.cnt - CountW'(1)));
  assign xfer    = head_i.valid && out_o.ready;
  assign pop_o   = xfer && is_last;

  assign out_o.valid       = head_i.valid;
  assign out_o.item_kind   = cur.kind;
  assign out_o.out_byte    = cur.data;
  assign out_o.last_result = is_last;

  // Result index within the current bundle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (xfer) begin
      if (is_last) begin
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + SlotW'(1);
      end
    end
  end

endmodule

@@ hdl/url_query_string_decoder.sv @@
// Path: the results of an accepted byte are written into the queue and offered from its head.
// Throughput: one byte per cycle while bytes give at most one result each and the output is
// not held back; a byte that gives several results sends them one transaction at a time,
// and a two-entry queue of per-byte result groups lets input continue meanwhile.
// Reset: asynchronous, active low; clears the parser state and empties the queue.
`timescale 1ns / 1ps

module url_query_string_decoder
  import urlqd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  urlqd_in_if.sink    in_i,
  urlqd_out_if.source out_o
);

  logic    full, push, pop;
  bundle_t bundle;
  qhead_t  head;

  // Front end: parses bytes into result groups.
  urlqd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .full_i   (full),
    .push_o   (push),
    .bundle_o (bundle)
  );

  // Queue between front and back.
  urlqd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .full_o   (full),
    .pop_i    (pop),
    .head_o   (head)
  );

  // Back end: sends results one transaction at a time.
  urlqd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
